// File: hdl/u2a_pkg.sv
// ---------------------------------------------------------------------------
// u2a_pkg: shared types and constants for the UTF-16 to ASCII folder
// Item structs, code point constants, register map and the fold function.
// ---------------------------------------------------------------------------
package u2a_pkg;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic       write_en;
    logic [6:0] out_char;
    logic [7:0] write_pos;
    logic [7:0] text_len;
    logic       string_done;
  } out_item_t;

  typedef struct packed {
    logic       hit;
    logic [6:0] ch;
  } fold_t;

  // register map (register index = paddr[2])
  localparam logic REG_OUT_LIMIT = 1'b0;
  localparam logic [7:0] OUT_LIMIT_RESET = 8'd63;

  localparam logic [15:0] CODE_NUL    = 16'h0000;
  localparam logic [15:0] CODE_LF     = 16'h000A;
  localparam logic [15:0] CODE_CR     = 16'h000D;
  localparam logic [15:0] CODE_NBSP   = 16'h00A0;
  localparam logic [15:0] CODE_COPY   = 16'h00A9;
  localparam logic [15:0] CODE_REG    = 16'h00AE;
  localparam logic [15:0] CODE_TM     = 16'h2122;
  localparam logic [15:0] CODE_LSQUO  = 16'h2018;
  localparam logic [15:0] CODE_RSQUO  = 16'h2019;
  localparam logic [15:0] CODE_LDQUO  = 16'h201C;
  localparam logic [15:0] CODE_RDQUO  = 16'h201D;
  localparam logic [15:0] CODE_ENDASH = 16'h2013;
  localparam logic [15:0] CODE_EMDASH = 16'h2014;
  localparam logic [15:0] CODE_ASCII_END = 16'h0080;

  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_QMARK = 7'h3F;

  function automatic logic in_rng(input logic [15:0] c, input logic [15:0] lo,
                                  input logic [15:0] hi);
    in_rng = (c >= lo) && (c <= hi);
  endfunction

  // Latin-1 letters to base letter, typographic quotes/dashes, no-break space.
  function automatic fold_t fold_code(input logic [15:0] c);
    fold_t f;
    f.hit = 1'b1;
    f.ch  = 7'h00;
    if (in_rng(c, 16'h00C0, 16'h00C5))                      f.ch = 7'("A");
    else if (c == 16'h00C7)                                  f.ch = 7'("C");
    else if (in_rng(c, 16'h00C8, 16'h00CB))                  f.ch = 7'("E");
    else if (in_rng(c, 16'h00CC, 16'h00CF))                  f.ch = 7'("I");
    else if (c == 16'h00D1)                                  f.ch = 7'("N");
    else if (in_rng(c, 16'h00D2, 16'h00D6) || c == 16'h00D8) f.ch = 7'("O");
    else if (in_rng(c, 16'h00D9, 16'h00DC))                  f.ch = 7'("U");
    else if (c == 16'h00DD)                                  f.ch = 7'("Y");
    else if (in_rng(c, 16'h00E0, 16'h00E5))                  f.ch = 7'("a");
    else if (c == 16'h00E7)                                  f.ch = 7'("c");
    else if (in_rng(c, 16'h00E8, 16'h00EB))                  f.ch = 7'("e");
    else if (in_rng(c, 16'h00EC, 16'h00EF))                  f.ch = 7'("i");
    else if (c == 16'h00F1)                                  f.ch = 7'("n");
    else if (in_rng(c, 16'h00F2, 16'h00F6) || c == 16'h00F8) f.ch = 7'("o");
    else if (in_rng(c, 16'h00F9, 16'h00FC))                  f.ch = 7'("u");
    else if (c == 16'h00FD || c == 16'h00FF)                 f.ch = 7'("y");
    else if (c == CODE_LSQUO || c == CODE_RSQUO)             f.ch = 7'("'");
    else if (c == CODE_LDQUO || c == CODE_RDQUO)             f.ch = 7'("\"");
    else if (c == CODE_ENDASH || c == CODE_EMDASH)           f.ch = 7'("-");
    else if (c == CODE_NBSP)                                 f.ch = CH_SPACE;
    else                                                     f.hit = 1'b0;
    return f;
  endfunction

endpackage

// File: hdl/u2a_stream_if.sv
// ---------------------------------------------------------------------------
// u2a_stream_if: valid/ready channel
// Carries one payload item per transfer; type set per instance.
// ---------------------------------------------------------------------------
interface u2a_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/utf16_to_ascii_folder.sv
// ---------------------------------------------------------------------------
// utf16_to_ascii_folder: UTF-16 code unit stream to folded ASCII text
// Converts one code unit per cycle, unless the receiver stalls, into buffer writes plus trimmed length.
// ---------------------------------------------------------------------------
// Usage:
//   in_if  (sink)  : one UTF-16 code unit per transfer, plus a last flag that
//                    marks the end of the string's field.
//   out_if (source): exactly one result per input transfer: an optional
//                    buffer write (write_en, out_char, write_pos), the text
//                    length with trailing spaces trimmed, and string_done.
//   APB port       : one register, out_limit at byte address 0 (reset 63).
//                    Write it only while the block is idle.
// Each input item is registered in the input register and its result in the
// result register; throughput is one item per cycle while the receiver does
// not stall, set by the update of the running string state (position,
// last-was-space, trimmed length, halted).
// Reset (synchronous, rst_n low) empties both pipeline registers, clears the
// string state and restores out_limit. When the receiver stalls, the result
// register holds, the input register fills, and then in_if.ready drops; no
// item is lost or repeated.
// ---------------------------------------------------------------------------
module utf16_to_ascii_folder (
  input  logic        clk,
  input  logic        rst_n,
  u2a_stream_if.sink   in_if,
  u2a_stream_if.source out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---- configuration register ----
  logic [7:0] out_limit_r;

  assign pready = 1'b1;
  // only one register: anything at index 1 reads as zero and is not written
  assign prdata = (paddr[2] == u2a_pkg::REG_OUT_LIMIT) ? {24'd0, out_limit_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_limit_r <= u2a_pkg::OUT_LIMIT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == u2a_pkg::REG_OUT_LIMIT) begin
      out_limit_r <= pwdata[7:0];
    end
  end

  // ---- pipeline control ----
  // Stage 1 is the input register, stage 2 the result register. The string
  // state updates when an item moves from stage 1 to stage 2, so the next
  // item already sees it with no bubble.
  logic               s1_valid_r;
  u2a_pkg::in_item_t  s1_item_r;
  logic               out_valid_r;
  u2a_pkg::out_item_t out_item_r;
  logic               advance;

  assign advance      = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready  = !s1_valid_r || advance;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_item_r;

  // ---- running string state ----
  logic [7:0] next_pos_r,    next_pos_nxt;
  logic       prev_space_r,  prev_space_nxt;
  logic [7:0] trim_len_r,    trim_len_nxt;
  logic       halted_r,      halted_nxt;
  u2a_pkg::out_item_t result;

  // ---- per-item conversion ----
  logic [15:0]    code;
  logic           halt_now;
  logic           wr;
  logic [6:0]     ch;
  logic [7:0]     pos_inc;
  u2a_pkg::fold_t fold;

  assign code    = s1_item_r.code_unit;
  assign fold    = u2a_pkg::fold_code(code);
  assign pos_inc = next_pos_r + 8'd1;

  always_comb begin
    // a zero unit or a full buffer stops the string until its last unit
    halt_now = halted_r || code == u2a_pkg::CODE_NUL || next_pos_r >= out_limit_r;
    wr = 1'b0;
    ch = 7'd0;
    if (!halt_now) begin
      if (code == u2a_pkg::CODE_LF || code == u2a_pkg::CODE_CR) begin
        // line break collapses to one space, never leading
        wr = (next_pos_r != 8'd0) && !prev_space_r;
        ch = u2a_pkg::CH_SPACE;
      end else if (code < u2a_pkg::CODE_ASCII_END) begin
        wr = 1'b1;
        ch = code[6:0];
      end else if (fold.hit) begin
        wr = 1'b1;
        ch = fold.ch;
      end else if (code != u2a_pkg::CODE_TM && code != u2a_pkg::CODE_REG &&
                   code != u2a_pkg::CODE_COPY) begin
        wr = 1'b1;
        ch = u2a_pkg::CH_QMARK;
      end
    end

    next_pos_nxt   = next_pos_r;
    prev_space_nxt = prev_space_r;
    trim_len_nxt   = trim_len_r;
    halted_nxt     = halt_now;
    if (wr) begin
      next_pos_nxt   = pos_inc;
      prev_space_nxt = (ch == u2a_pkg::CH_SPACE);
      if (ch != u2a_pkg::CH_SPACE) begin
        trim_len_nxt = pos_inc;
      end
    end

    result.write_en    = wr;
    result.out_char    = wr ? ch : 7'd0;
    result.write_pos   = wr ? next_pos_r : 8'd0;
    result.text_len    = trim_len_nxt;
    result.string_done = s1_item_r.last;

    // last unit closes the string: state starts fresh for the next one
    if (s1_item_r.last) begin
      next_pos_nxt   = 8'd0;
      prev_space_nxt = 1'b0;
      trim_len_nxt   = 8'd0;
      halted_nxt     = 1'b0;
    end
  end

  // ---- registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      next_pos_r   <= 8'd0;
      prev_space_r <= 1'b0;
      trim_len_r   <= 8'd0;
      halted_r     <= 1'b0;
    end else begin
      if (in_if.ready) begin
        s1_valid_r <= in_if.valid;
      end
      if (advance) begin
        out_valid_r  <= 1'b1;
        next_pos_r   <= next_pos_nxt;
        prev_space_r <= prev_space_nxt;
        trim_len_r   <= trim_len_nxt;
        halted_r     <= halted_nxt;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_item_r <= in_if.data;
    end
    if (advance) begin
      out_item_r <= result;
    end
  end

endmodule
